[rtl/core/ptm_pkg.sv]
// shared constants, types and constant functions for the power-law tone mapper
`timescale 1ns / 1ps

package ptm_pkg;

    localparam int LOG_FRAC   = 24;   // fraction bits of every log2 value
    localparam int LOG_STEPS  = 24;   // squaring steps per log2
    localparam int NORM_W     = 64;   // normalizer word for a pixel
    localparam int NORM_STEPS = 6;    // binary leading-zero steps over NORM_W
    localparam int EXP_MANT   = 30;   // exp2 mantissa fraction bits (Q2.30)
    localparam int GAMMA_FRAC = 40;   // fraction bits of the gamma argument
    localparam int DIV_BITS   = 50;   // dividend bits of gamma_w << 24

    localparam logic signed [31:0] GAMMA_HI   = 32'sd44543754;
    localparam logic signed [31:0] GAMMA_BASE = 32'sd31121736;
    localparam logic signed [31:0] LOG2_255   = 32'sd134122994;
    localparam logic [29:0]        GAMMA_SLOPE = 30'd517165595;
    localparam logic [31:0]        OFFSET_Q40  = 32'd2528877;

    // configuration register indexes
    localparam logic CFG_DISPLAY = 1'b0;
    localparam logic CFG_WORLD   = 1'b1;

    // coefficients held between configuration writes
    typedef struct packed {
        logic signed [31:0] log_wa;   // log2 of world adaptation, Q.24
        logic [31:0]        expo;     // exponent f, Q8.24
        logic signed [31:0] c_off;    // log2(Lda) - log2(255) + frac bits, Q.24
    } ptm_coef_t;

    // truncated integer square root
    function automatic logic [63:0] ptm_isqrt(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] b;
        n   = n_in;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= res + b)
            begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) in Q2.30 by k chained square roots of 2.0
    function automatic logic [31:0] ptm_exp_root(input int k);
        logic [63:0] r;
        r = 64'd2 << EXP_MANT;
        for (int i = 0; i < LOG_STEPS; i++)
        begin
            if (i < k)
            begin
                r = ptm_isqrt(r << EXP_MANT);
            end
        end
        return r[31:0];
    endfunction

endpackage

[rtl/core/ptm_log2_pipe.sv]
// pipelined log2 of a pixel luminance: leading-zero normalize then squaring stages
`timescale 1ns / 1ps

module ptm_log2_pipe
    import ptm_pkg::*;
#(
    parameter int LUM_WIDTH     = 32,
    parameter int LUM_FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [LUM_WIDTH-1:0]     in_lum,
    output logic                     out_valid,
    output logic                     out_zero,
    output logic signed [31:0]       out_log
);

    localparam int CNT_W = $clog2(NORM_W);

    logic [NORM_W-1:0] nrm_reg   [0:NORM_STEPS];
    logic [CNT_W-1:0]  cnt_reg   [0:NORM_STEPS];
    logic              nvld_reg  [0:NORM_STEPS];
    logic              nzero_reg [0:NORM_STEPS];

    logic [31:0]       m_reg     [0:LOG_STEPS];
    logic [LOG_FRAC-1:0] frac_reg [0:LOG_STEPS];
    logic signed [7:0] int_reg   [0:LOG_STEPS];
    logic              svld_reg  [0:LOG_STEPS];
    logic              szero_reg [0:LOG_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nvld_reg[0] <= 1'b0;
        end
        else
        begin
            nvld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        nrm_reg[0]   <= NORM_W'(in_lum);
        cnt_reg[0]   <= '0;
        nzero_reg[0] <= (in_lum == '0);
    end

    // binary search for the leading one, one shift size per stage
    for (genvar s = 0; s < NORM_STEPS; s++)
    begin : g_norm
        localparam int SH = (NORM_W / 2) >> s;
        logic hit;
        assign hit = (nrm_reg[s][NORM_W-1 -: SH] == '0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                nvld_reg[s+1] <= 1'b0;
            end
            else
            begin
                nvld_reg[s+1] <= nvld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            nrm_reg[s+1]   <= hit ? (nrm_reg[s] << SH) : nrm_reg[s];
            cnt_reg[s+1]   <= hit ? (cnt_reg[s] + CNT_W'(SH)) : cnt_reg[s];
            nzero_reg[s+1] <= nzero_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            svld_reg[0] <= 1'b0;
        end
        else
        begin
            svld_reg[0] <= nvld_reg[NORM_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg[0]     <= nrm_reg[NORM_STEPS][NORM_W-1 -: 32];
        frac_reg[0]  <= '0;
        int_reg[0]   <= 8'(NORM_W - 1) - 8'(cnt_reg[NORM_STEPS]) - 8'(LUM_FRAC_BITS);
        szero_reg[0] <= nzero_reg[NORM_STEPS];
    end

    // each squaring of the Q1.31 mantissa yields one fraction bit
    for (genvar k = 0; k < LOG_STEPS; k++)
    begin : g_sqr
        logic [63:0] sq;
        assign sq = m_reg[k] * m_reg[k];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                svld_reg[k+1] <= 1'b0;
            end
            else
            begin
                svld_reg[k+1] <= svld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            m_reg[k+1]     <= sq[63] ? sq[63:32] : sq[62:31];
            frac_reg[k+1]  <= {frac_reg[k][LOG_FRAC-2:0], sq[63]};
            int_reg[k+1]   <= int_reg[k];
            szero_reg[k+1] <= szero_reg[k];
        end
    end

    assign out_valid = svld_reg[LOG_STEPS];
    assign out_zero  = szero_reg[LOG_STEPS];
    assign out_log   = $signed({int_reg[LOG_STEPS], frac_reg[LOG_STEPS]});

endmodule

[rtl/core/ptm_derive.sv]
// configuration registers and the sequential unit that derives the exponent
`timescale 1ns / 1ps

module ptm_derive
    import ptm_pkg::*;
#(
    parameter int LUM_WIDTH     = 32,
    parameter int LUM_FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic                 wr_index,
    input  logic [LUM_WIDTH-1:0] wr_data,
    output logic                 busy,
    output ptm_coef_t            coef
);

    localparam int VW      = LUM_WIDTH + GAMMA_FRAC - LUM_FRAC_BITS;
    localparam int SW      = $clog2(VW + 1);
    localparam int MIN_RAW = (66 * 256) >> (24 - LUM_FRAC_BITS);
    localparam logic [LUM_WIDTH-1:0] ADAPT_MIN = LUM_WIDTH'((MIN_RAW == 0) ? 1 : MIN_RAW);
    localparam logic [LUM_WIDTH-1:0] LUM_100   = LUM_WIDTH'(100) << LUM_FRAC_BITS;
    localparam logic [LUM_WIDTH-1:0] LUM_ONE   = LUM_WIDTH'(1) << LUM_FRAC_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_NORM  = 3'd2;
    localparam logic [2:0] ST_SQR   = 3'd3;
    localparam logic [2:0] ST_STORE = 3'd4;
    localparam logic [2:0] ST_DINIT = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    logic [LUM_WIDTH-1:0] dal_reg;
    logic [LUM_WIDTH-1:0] wal_reg;
    logic [2:0]           state_reg;
    logic [1:0]           op_reg;     // 0 log Lwa, 1 log Lda, 2 gamma Lwa, 3 gamma Lda
    logic [VW-1:0]        v_reg;
    logic [SW-1:0]        s_reg;
    logic [31:0]          m_reg;
    logic [LOG_FRAC-1:0]  frac_reg;
    logic [5:0]           step_reg;
    logic signed [31:0]   gw_reg;
    logic signed [31:0]   gd_reg;
    logic signed [31:0]   log_wa_reg;
    logic signed [31:0]   log_da_reg;
    logic [31:0]          expo_reg;
    logic signed [31:0]   c_off_reg;
    logic [DIV_BITS-1:0]  quo_reg;
    logic [27:0]          rem_reg;

    logic [LUM_WIDTH-1:0] wr_clamped;
    logic [LUM_WIDTH-1:0] lum_sel;
    logic [63:0]          sq;
    logic signed [7:0]    lg_int;
    logic signed [31:0]   lg;
    logic signed [64:0]   gprod;
    logic signed [31:0]   gamma_next;
    logic [28:0]          rem_shift;
    logic                 quo_bit;

    assign wr_clamped = (wr_data < ADAPT_MIN) ? ADAPT_MIN : wr_data;
    assign lum_sel    = op_reg[0] ? dal_reg : wal_reg;
    assign sq         = m_reg * m_reg;
    assign lg_int     = 8'(VW - 1) - 8'(s_reg)
                        - (op_reg[1] ? 8'(GAMMA_FRAC) : 8'(LUM_FRAC_BITS));
    assign lg         = $signed({lg_int, frac_reg});
    assign gprod      = lg * $signed({3'b000, GAMMA_SLOPE});
    assign gamma_next = GAMMA_BASE + 32'(gprod >>> 32);
    assign rem_shift  = {rem_reg, quo_reg[DIV_BITS-1]};
    assign quo_bit    = (rem_shift >= 29'(gd_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dal_reg   <= LUM_100;
            wal_reg   <= LUM_ONE;
            state_reg <= ST_LOAD;
            op_reg    <= 2'd0;
        end
        else if (wr_en)
        begin
            if (wr_index == CFG_DISPLAY)
            begin
                dal_reg <= wr_clamped;
            end
            else
            begin
                wal_reg <= wr_clamped;
            end
            state_reg <= ST_LOAD;
            op_reg    <= 2'd0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (op_reg[1] && lum_sel > LUM_100)
                    begin
                        if (op_reg == 2'd3)
                        begin
                            state_reg <= ST_DINIT;
                        end
                        op_reg <= op_reg + 2'd1;
                    end
                    else
                    begin
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    if (v_reg[VW-1])
                    begin
                        state_reg <= ST_SQR;
                    end
                end
                ST_SQR:
                begin
                    if (step_reg == 6'(LOG_STEPS - 1))
                    begin
                        state_reg <= ST_STORE;
                    end
                end
                ST_STORE:
                begin
                    state_reg <= (op_reg == 2'd3) ? ST_DINIT : ST_LOAD;
                    op_reg    <= op_reg + 2'd1;
                end
                ST_DINIT:
                begin
                    state_reg <= (gw_reg <= 0 || gd_reg <= 0) ? ST_FIN : ST_DIV;
                end
                ST_DIV:
                begin
                    if (step_reg == 6'(DIV_BITS - 1))
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LOAD:
            begin
                if (op_reg[1] && lum_sel > LUM_100)
                begin
                    if (op_reg[0])
                    begin
                        gd_reg <= GAMMA_HI;
                    end
                    else
                    begin
                        gw_reg <= GAMMA_HI;
                    end
                end
                v_reg <= op_reg[1]
                    ? (VW'(lum_sel) << (GAMMA_FRAC - LUM_FRAC_BITS)) + VW'(OFFSET_Q40)
                    : VW'(lum_sel);
                s_reg <= '0;
            end
            ST_NORM:
            begin
                m_reg    <= v_reg[VW-1 -: 32];
                frac_reg <= '0;
                step_reg <= '0;
                if (!v_reg[VW-1])
                begin
                    v_reg <= v_reg << 1;
                    s_reg <= s_reg + SW'(1);
                end
            end
            ST_SQR:
            begin
                m_reg    <= sq[63] ? sq[63:32] : sq[62:31];
                frac_reg <= {frac_reg[LOG_FRAC-2:0], sq[63]};
                step_reg <= step_reg + 6'd1;
            end
            ST_STORE:
            begin
                case (op_reg)
                    2'd0:    log_wa_reg <= lg;
                    2'd1:    log_da_reg <= lg;
                    2'd2:    gw_reg     <= gamma_next;
                    default: gd_reg     <= gamma_next;
                endcase
            end
            ST_DINIT:
            begin
                expo_reg <= '0;
                quo_reg  <= DIV_BITS'(gw_reg) << LOG_FRAC;
                rem_reg  <= '0;
                step_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg  <= quo_bit ? 28'(rem_shift - 29'(gd_reg)) : rem_shift[27:0];
                quo_reg  <= {quo_reg[DIV_BITS-2:0], quo_bit};
                step_reg <= step_reg + 6'd1;
            end
            ST_FIN:
            begin
                if (gw_reg > 0 && gd_reg > 0)
                begin
                    expo_reg <= (quo_reg[DIV_BITS-1:32] != '0) ? '1 : quo_reg[31:0];
                end
                c_off_reg <= log_da_reg - LOG2_255 + (32'sd1 <<< LOG_FRAC) * LUM_FRAC_BITS;
            end
            default:
            begin
            end
        endcase
    end

    assign busy        = (state_reg != ST_IDLE);
    assign coef.log_wa = log_wa_reg;
    assign coef.expo   = expo_reg;
    assign coef.c_off  = c_off_reg;

endmodule

[rtl/core/power_law_tone_mapper_unit.sv]
// top level of the power-law tone mapper: log, scale, exp2 pipeline and output
`timescale 1ns / 1ps

// One luminance pixel per clock enters when start is high and busy is low; its
// result appears with done for one cycle after 6 normalize, 24 log2, the scale and
// 24 exp2 stages plus input and output registers, and must be taken then, since
// the receiver cannot stall. After reset and after every register write busy
// stays high while the exponent is derived by one shared squarer and a bit-serial
// divider: each of the four log2s shifts its normalizer word once per leading zero
// and then runs the squaring steps (a gamma whose luminance is above 100 is set to
// a constant instead) and then, if both gammas are positive, the divider runs.
// Write registers only while idle.

module power_law_tone_mapper_unit
    import ptm_pkg::*;
#(
    parameter int LUM_WIDTH     = 32,
    parameter int LUM_FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [LUM_WIDTH-1:0] pixel_lum,
    output logic                 busy,
    output logic                 done,
    output logic [LUM_WIDTH-1:0] display_lum,
    output logic                 saturated,
    input  logic                 wr_en,
    input  logic                 wr_index,
    input  logic [LUM_WIDTH-1:0] wr_data
);

    localparam int EW  = 44;
    localparam int SHW = $clog2(LUM_WIDTH + 1);
    localparam int TW  = 32 + LUM_WIDTH;
    localparam int VLW = LUM_WIDTH + 2;

    ptm_coef_t          coef;
    logic               accept;
    logic               lg_valid;
    logic               lg_zero;
    logic signed [31:0] lg_log;

    assign accept = start & ~busy;

    ptm_derive #(
        .LUM_WIDTH     (LUM_WIDTH),
        .LUM_FRAC_BITS (LUM_FRAC_BITS)
    ) u_derive (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .busy     (busy),
        .coef     (coef)
    );

    ptm_log2_pipe #(
        .LUM_WIDTH     (LUM_WIDTH),
        .LUM_FRAC_BITS (LUM_FRAC_BITS)
    ) u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_lum    (pixel_lum),
        .out_valid (lg_valid),
        .out_zero  (lg_zero),
        .out_log   (lg_log)
    );

    // scale stages: d = log L - log Lwa, p = f * d, e = offset + floor(p)
    logic               d_vld_reg;
    logic               d_zero_reg;
    logic signed [32:0] d_reg;
    logic               p_vld_reg;
    logic               p_zero_reg;
    logic signed [65:0] p_reg;
    logic signed [EW-1:0] e_next;
    logic signed [19:0] ip_next;
    logic               ovf_next;
    logic               unf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
        end
        else
        begin
            d_vld_reg <= lg_valid;
            p_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg      <= 33'(lg_log) - 33'(coef.log_wa);
        d_zero_reg <= lg_zero;
        p_reg      <= $signed({1'b0, coef.expo}) * d_reg;
        p_zero_reg <= d_zero_reg;
    end

    assign e_next   = EW'(coef.c_off) + EW'(p_reg >>> LOG_FRAC);
    assign ip_next  = e_next[EW-1:LOG_FRAC];
    assign ovf_next = (ip_next >= 20'sd0 + LUM_WIDTH);
    assign unf_next = (ip_next < -20'sd1);

    // exp2 stages: mantissa times 2^(2^-k) for each set fraction bit
    logic               x_vld_reg  [0:LOG_STEPS];
    logic               x_zero_reg [0:LOG_STEPS];
    logic               x_ovf_reg  [0:LOG_STEPS];
    logic [LOG_FRAC-1:0] x_fr_reg  [0:LOG_STEPS];
    logic [SHW-1:0]     x_sh_reg   [0:LOG_STEPS];
    logic [31:0]        x_m_reg    [0:LOG_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_vld_reg[0] <= 1'b0;
        end
        else
        begin
            x_vld_reg[0] <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_zero_reg[0] <= p_zero_reg | (unf_next & ~ovf_next);
        x_ovf_reg[0]  <= ovf_next & ~p_zero_reg;
        x_fr_reg[0]   <= e_next[LOG_FRAC-1:0];
        x_sh_reg[0]   <= SHW'(ip_next + 20'sd1);
        x_m_reg[0]    <= 32'd1 << EXP_MANT;
    end

    for (genvar k = 0; k < LOG_STEPS; k++)
    begin : g_exp
        localparam logic [31:0] ROOT = ptm_exp_root(k + 1);
        logic [63:0] prod;
        assign prod = x_m_reg[k] * ROOT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                x_vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                x_vld_reg[k+1] <= x_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            x_m_reg[k+1]    <= x_fr_reg[k][LOG_FRAC-1-k]
                               ? prod[EXP_MANT+31:EXP_MANT] : x_m_reg[k];
            x_fr_reg[k+1]   <= x_fr_reg[k];
            x_sh_reg[k+1]   <= x_sh_reg[k];
            x_zero_reg[k+1] <= x_zero_reg[k];
            x_ovf_reg[k+1]  <= x_ovf_reg[k];
        end
    end

    // final scaling: (m << (ip + 1) + 2^30) >> 31 rounds half up
    logic          t_vld_reg;
    logic          t_zero_reg;
    logic          t_ovf_reg;
    logic [TW-1:0] t_reg;
    logic [TW:0]   t_round;
    logic [VLW-1:0] val;
    logic          done_reg;
    logic [LUM_WIDTH-1:0] disp_reg;
    logic          sat_reg;
    logic          over;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            t_vld_reg <= x_vld_reg[LOG_STEPS];
            done_reg  <= t_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= TW'(x_m_reg[LOG_STEPS]) << x_sh_reg[LOG_STEPS];
        t_zero_reg <= x_zero_reg[LOG_STEPS];
        t_ovf_reg  <= x_ovf_reg[LOG_STEPS];
    end

    assign t_round = {1'b0, t_reg} + ((TW + 1)'(1) << EXP_MANT);
    assign val     = t_round[TW:31];
    assign over    = t_ovf_reg | (val[VLW-1:LUM_WIDTH] != '0);

    always_ff @(posedge clk)
    begin
        if (t_zero_reg)
        begin
            disp_reg <= '0;
            sat_reg  <= 1'b0;
        end
        else if (over)
        begin
            disp_reg <= '1;
            sat_reg  <= 1'b1;
        end
        else
        begin
            disp_reg <= val[LUM_WIDTH-1:0];
            sat_reg  <= 1'b0;
        end
    end

    assign done        = done_reg;
    assign display_lum = disp_reg;
    assign saturated   = sat_reg;

endmodule
